>>> sv/vea_pkg.sv
// Shared constants, types and codes of the voxel EMA accumulator.
package vea_pkg;

  localparam int ENTRIES = 1024;
  localparam int ADDR_W = $clog2(ENTRIES);
  localparam int CNT_W = ADDR_W + 1;
  localparam int MAXE_W = 11;
  localparam int CMP_W = (CNT_W > MAXE_W) ? CNT_W : MAXE_W;

  localparam int POS_W = 24;
  localparam int FEAT_W = 16;
  localparam int MA_W = 25;
  localparam int MB_W = 18;
  localparam int PROD_W = MA_W + MB_W;
  localparam int TAG_W = 4;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 23;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_VOXEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_OBS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENT = 3'd4;

  localparam logic [1:0] STAT_UPDATED = 2'd0;
  localparam logic [1:0] STAT_CREATED = 2'd1;
  localparam logic [1:0] STAT_DROPPED = 2'd2;
  localparam logic [1:0] STAT_PRUNED = 2'd3;

  typedef struct packed {
    logic [2:0][POS_W-1:0]  key;
    logic [2:0][POS_W-1:0]  pos;
    logic [4:0][FEAT_W-1:0] feat;
    logic [7:0]             cls;
    logic                   pas;
    logic [15:0]            cnt;
  } slot_t;

  typedef struct packed {
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_data_en;
    logic              wr_vld_en;
    logic              wr_vld;
    logic [ADDR_W-1:0] wr_addr;
  } store_cmd_t;

endpackage

>>> sv/vea_store.sv
// Slot memories: entry payload and valid bits, one read and one write a cycle.
module vea_store (
  input  logic               clk_i,
  input  vea_pkg::store_cmd_t cmd_i,
  input  vea_pkg::slot_t     wr_data_i,
  output vea_pkg::slot_t     rd_data_o,
  output logic               rd_vld_o
);
  import vea_pkg::*;

  slot_t mem_q [ENTRIES];
  logic  vld_mem_q [ENTRIES];
  slot_t rd_data_q;
  logic  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_data_en) begin
      mem_q[cmd_i.wr_addr] <= wr_data_i;
    end
    if (cmd_i.wr_vld_en) begin
      vld_mem_q[cmd_i.wr_addr] <= cmd_i.wr_vld;
    end
    rd_data_q <= mem_q[cmd_i.rd_addr];
    rd_vld_q  <= vld_mem_q[cmd_i.rd_addr];
  end

  assign rd_data_o = rd_data_q;
  assign rd_vld_o  = rd_vld_q;

endmodule

>>> sv/vea_mul.sv
// Shared registered multiplier with an operation tag.
module vea_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_vld_i,
  input  logic signed [vea_pkg::MA_W-1:0]   a_i,
  input  logic signed [vea_pkg::MB_W-1:0]   b_i,
  input  logic [vea_pkg::TAG_W-1:0]         tag_i,
  output logic                              vld_o,
  output logic [vea_pkg::TAG_W-1:0]         tag_o,
  output logic signed [vea_pkg::PROD_W-1:0] prod_o
);
  import vea_pkg::*;

  logic                     vld_q;
  logic [TAG_W-1:0]         tag_q;
  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q  <= tag_i;
    prod_q <= a_i * b_i;
  end

  assign vld_o  = vld_q;
  assign tag_o  = tag_q;
  assign prod_o = prod_q;

endmodule

>>> sv/voxel_ema_accumulator.sv
// Top level: voxel map sequencer around the slot memories and the shared multiplier.
// Accumulate beat: key math, a scan of the slots (stops at the first key match), blending on
// a match, then the write state. Prune beat: distance scan, a middle state, a count scan (only
// when occupancy exceeds the entry limit), then the result state. Each beat also spends its
// accept cycle in idle; the final state waits for a free result register. After reset a
// clearing pass over all ENTRIES slots runs.
module voxel_ema_accumulator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [vea_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [vea_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // pos_x, pos_y, pos_z, intensity, slope, roughness, curvature, hvar,
  // label, traversable, zero fill
  input  logic [167:0]                       s_axis_tdata_i,
  // action
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // count_value, out_x, out_y, out_z, out_intensity, out_slope, out_roughness,
  // out_curvature, out_hvar, out_class, out_traversable, zero fill
  output logic [183:0]                       m_axis_tdata_o,
  // status
  output logic [1:0]                         m_axis_tuser_o
);
  import vea_pkg::*;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_KEY, ST_SCAN, ST_EMA, ST_WRITE, ST_PR1, ST_PRMID, ST_PR2, ST_FIN
  } state_e;

  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(ENTRIES - 1);

  state_e state_q;

  logic [15:0] inv_q;
  logic [16:0] alpha_q;
  logic [15:0] min_obs_q;
  logic [22:0] radius_q;
  logic [10:0] max_ent_q;

  slot_t pnt_q, slot_q;
  logic [CNT_W-1:0]  ra_q, occ_q, removed_q;
  logic [CMP_W-1:0]  excess_q;
  logic              pv_q;
  logic [ADDR_W-1:0] paddr_q, hit_idx_q, free_idx_q;
  logic              hit_q, free_fnd_q;
  logic [4:0]        mc_q;
  logic signed [PROD_W-1:0] t_q;
  logic [7:0][POS_W-1:0] res_q;
  logic [45:0]       r2_q;
  logic              v1_q, v2_q, l1_q, l2_q;
  logic [ADDR_W-1:0] a1_q, a2_q;
  logic [MA_W-1:0]   adx_q, ady_q;
  logic [49:0]       sqx_q, sqy_q;

  logic          m_vld_q;
  logic [183:0]  m_data_q;
  logic [1:0]    m_user_q;

  store_cmd_t cmd;
  slot_t      rd_data, upd_w;
  logic       rd_vld;

  logic                     mul_in_vld, mul_vld;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic [TAG_W-1:0]         mul_tag, mul_tag_o;
  logic signed [PROD_W-1:0] mul_prod;
  logic signed [PROD_W:0]   ema_sum;

  logic [16:0] alpha_c, beta_c;
  logic signed [MA_W-1:0] vold [8];
  logic signed [MA_W-1:0] pnew [8];
  logic        out_free, out_load, key_hit, far, kill, scan_more;
  logic [15:0] cnt_inc;
  logic signed [MA_W-1:0] dx, dy;
  logic [CNT_W-1:0] ra_inc;

  vea_store u_store (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .wr_data_i (hit_q ? upd_w : pnt_q),
    .rd_data_o (rd_data),
    .rd_vld_o  (rd_vld)
  );

  vea_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_vld_i (mul_in_vld),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .tag_i    (mul_tag),
    .vld_o    (mul_vld),
    .tag_o    (mul_tag_o),
    .prod_o   (mul_prod)
  );

  // Position fields sign-extend, intensity zero-extends, the other features sign-extend.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vold[i] = MA_W'(signed'(slot_q.pos[i]));
      pnew[i] = MA_W'(signed'(pnt_q.pos[i]));
    end
    vold[3] = signed'({9'd0, slot_q.feat[0]});
    pnew[3] = signed'({9'd0, pnt_q.feat[0]});
    for (int i = 1; i < 5; i++) begin
      vold[3+i] = MA_W'(signed'(slot_q.feat[i]));
      pnew[3+i] = MA_W'(signed'(pnt_q.feat[i]));
    end
  end

  assign alpha_c = (alpha_q > 17'd65536) ? 17'd65536 : alpha_q;
  assign beta_c  = 17'd65536 - alpha_c;

  always_comb begin
    mul_in_vld = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    mul_tag    = mc_q[TAG_W-1:0];
    if (state_q == ST_KEY) begin
      mul_in_vld = (mc_q < 5'd3);
      mul_a      = MA_W'(signed'(pnt_q.pos[mc_q[1:0]]));
      mul_b      = signed'({2'b00, inv_q});
    end else if (state_q == ST_EMA) begin
      mul_in_vld = (mc_q < 5'd16);
      mul_a      = mc_q[0] ? pnew[mc_q[3:1]] : vold[mc_q[3:1]];
      mul_b      = signed'({1'b0, mc_q[0] ? alpha_c : beta_c});
    end
  end

  assign ema_sum = {t_q[PROD_W-1], t_q} + {mul_prod[PROD_W-1], mul_prod};

  // Updated entry after blending.
  assign cnt_inc = (slot_q.cnt == 16'hFFFF) ? slot_q.cnt : slot_q.cnt + 16'd1;
  always_comb begin
    upd_w = slot_q;
    for (int i = 0; i < 3; i++) begin
      upd_w.pos[i] = res_q[i];
    end
    for (int i = 0; i < 5; i++) begin
      upd_w.feat[i] = res_q[3+i][FEAT_W-1:0];
    end
    upd_w.cnt = cnt_inc;
    if (cnt_inc >= min_obs_q) begin
      upd_w.cls = pnt_q.cls;
      upd_w.pas = pnt_q.pas;
    end
  end

  assign out_free  = !m_vld_q || m_axis_tready_i;
  assign out_load  = out_free && ((state_q == ST_WRITE) || (state_q == ST_FIN));
  assign key_hit   = rd_vld && (rd_data.key == pnt_q.key);
  assign scan_more = (ra_q < CNT_W'(ENTRIES));
  assign ra_inc    = ra_q + CNT_W'(1);
  assign dx = MA_W'(signed'(rd_data.pos[0])) - MA_W'(signed'(pnt_q.pos[0]));
  assign dy = MA_W'(signed'(rd_data.pos[1])) - MA_W'(signed'(pnt_q.pos[1]));
  assign far  = v2_q && (({1'b0, sqx_q} + {1'b0, sqy_q}) > {5'd0, r2_q});
  assign kill = pv_q && rd_vld && (rd_data.cnt < min_obs_q) && (excess_q != '0);

  always_comb begin
    cmd         = '0;
    cmd.rd_addr = ra_q[ADDR_W-1:0];
    unique case (state_q)
      ST_CLR: begin
        cmd.wr_vld_en = 1'b1;
        cmd.wr_addr   = ra_q[ADDR_W-1:0];
      end
      ST_WRITE: begin
        if (out_free && hit_q) begin
          cmd.wr_data_en = 1'b1;
          cmd.wr_addr    = hit_idx_q;
        end else if (out_free && free_fnd_q) begin
          cmd.wr_data_en = 1'b1;
          cmd.wr_vld_en  = 1'b1;
          cmd.wr_vld     = 1'b1;
          cmd.wr_addr    = free_idx_q;
        end
      end
      ST_PR1: begin
        cmd.wr_vld_en = far;
        cmd.wr_addr   = a2_q;
      end
      ST_PR2: begin
        cmd.wr_vld_en = kill;
        cmd.wr_addr   = paddr_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q     <= 16'd2560;
      alpha_q   <= 17'd19661;
      min_obs_q <= 16'd3;
      radius_q  <= 23'd5120;
      max_ent_q <= 11'd1024;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INV_VOXEL: inv_q     <= cfg_data_i[15:0];
        CFG_ALPHA:     alpha_q   <= cfg_data_i[16:0];
        CFG_MIN_OBS:   min_obs_q <= cfg_data_i[15:0];
        CFG_RADIUS:    radius_q  <= cfg_data_i;
        CFG_MAX_ENT:   max_ent_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      ra_q    <= '0;
      occ_q   <= '0;
      pv_q    <= 1'b0;
      m_vld_q <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      l1_q    <= 1'b0;
      l2_q    <= 1'b0;
      mc_q    <= '0;
    end else begin
      if (out_load) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLR: begin
          ra_q <= ra_inc;
          if (ra_q[ADDR_W-1:0] == LAST) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            pnt_q.pos[0]  <= s_axis_tdata_i[23:0];
            pnt_q.pos[1]  <= s_axis_tdata_i[47:24];
            pnt_q.pos[2]  <= s_axis_tdata_i[71:48];
            for (int i = 0; i < 5; i++) begin
              pnt_q.feat[i] <= s_axis_tdata_i[72+16*i +: 16];
            end
            pnt_q.cls     <= s_axis_tdata_i[159:152];
            pnt_q.pas     <= s_axis_tdata_i[160];
            pnt_q.cnt     <= 16'd1;
            r2_q          <= radius_q * radius_q;
            removed_q     <= '0;
            ra_q          <= '0;
            pv_q          <= 1'b0;
            v1_q          <= 1'b0;
            v2_q          <= 1'b0;
            l1_q          <= 1'b0;
            l2_q          <= 1'b0;
            mc_q          <= '0;
            hit_q         <= 1'b0;
            free_fnd_q    <= 1'b0;
            state_q       <= s_axis_tuser_i ? ST_PR1 : ST_KEY;
          end
        end
        ST_KEY: begin
          if (mc_q < 5'd3) begin
            mc_q <= mc_q + 5'd1;
          end
          if (mul_vld) begin
            pnt_q.key[mul_tag_o[1:0]] <= mul_prod[39:16];
            if (mul_tag_o == TAG_W'(2)) begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_more) begin
            ra_q <= ra_inc;
          end
          pv_q    <= scan_more;
          paddr_q <= ra_q[ADDR_W-1:0];
          if (pv_q) begin
            if (!rd_vld && !free_fnd_q) begin
              free_fnd_q <= 1'b1;
              free_idx_q <= paddr_q;
            end
            if (key_hit) begin
              hit_q     <= 1'b1;
              slot_q    <= rd_data;
              hit_idx_q <= paddr_q;
              mc_q      <= '0;
              state_q   <= ST_EMA;
            end else if (paddr_q == LAST) begin
              state_q <= ST_WRITE;
            end
          end
        end
        ST_EMA: begin
          if (mc_q < 5'd16) begin
            mc_q <= mc_q + 5'd1;
          end
          if (mul_vld) begin
            if (!mul_tag_o[0]) begin
              t_q <= mul_prod;
            end else begin
              res_q[mul_tag_o[3:1]] <= ema_sum[39:16];
            end
            if (mul_tag_o == TAG_W'(15)) begin
              state_q <= ST_WRITE;
            end
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            if (hit_q) begin
              m_user_q <= STAT_UPDATED;
              m_data_q <= {7'd0, upd_w.pas, upd_w.cls, upd_w.feat, upd_w.pos, upd_w.cnt};
            end else if (free_fnd_q) begin
              m_user_q <= STAT_CREATED;
              m_data_q <= {7'd0, pnt_q.pas, pnt_q.cls, pnt_q.feat, pnt_q.pos, pnt_q.cnt};
              occ_q    <= occ_q + CNT_W'(1);
            end else begin
              m_user_q <= STAT_DROPPED;
              m_data_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        ST_PR1: begin
          if (scan_more) begin
            ra_q <= ra_inc;
          end
          pv_q    <= scan_more;
          paddr_q <= ra_q[ADDR_W-1:0];
          v1_q    <= pv_q && rd_vld;
          l1_q    <= pv_q && (paddr_q == LAST);
          a1_q    <= paddr_q;
          adx_q   <= dx[MA_W-1] ? MA_W'(-dx) : MA_W'(dx);
          ady_q   <= dy[MA_W-1] ? MA_W'(-dy) : MA_W'(dy);
          v2_q    <= v1_q;
          l2_q    <= l1_q;
          a2_q    <= a1_q;
          sqx_q   <= adx_q * adx_q;
          sqy_q   <= ady_q * ady_q;
          if (far) begin
            occ_q     <= occ_q - CNT_W'(1);
            removed_q <= removed_q + CNT_W'(1);
          end
          if (l2_q) begin
            state_q <= ST_PRMID;
          end
        end
        ST_PRMID: begin
          ra_q <= '0;
          pv_q <= 1'b0;
          if (CMP_W'(occ_q) > CMP_W'(max_ent_q)) begin
            excess_q <= CMP_W'(occ_q) - CMP_W'(max_ent_q);
            state_q  <= ST_PR2;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_PR2: begin
          if (scan_more) begin
            ra_q <= ra_inc;
          end
          pv_q    <= scan_more;
          paddr_q <= ra_q[ADDR_W-1:0];
          if (kill) begin
            excess_q  <= excess_q - CMP_W'(1);
            occ_q     <= occ_q - CNT_W'(1);
            removed_q <= removed_q + CNT_W'(1);
          end
          if (pv_q && (paddr_q == LAST)) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_user_q <= STAT_PRUNED;
            if (CMP_W'(removed_q) > CMP_W'(16'hFFFF)) begin
              m_data_q <= {168'd0, 16'hFFFF};
            end else begin
              m_data_q <= {168'd0, 16'(removed_q)};
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(ENTRIES)) else $error("occupancy above table size");

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_vld_q && m_user_q == STAT_DROPPED) |-> (m_data_q == '0))
    else $error("dropped beat carries data");

  a_prune_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_vld_q && m_user_q == STAT_PRUNED) |-> (m_data_q[183:16] == '0))
    else $error("prune beat carries voxel data");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.wr_data_en && state_q == ST_WRITE) |=> (state_q == ST_IDLE))
    else $error("entry write without leaving write state");

endmodule
